[rtl/dijkstra_shortest_path_engine_assert.svh]
// Assertion macros used by the engine RTL.
`ifndef DIJKSTRA_SHORTEST_PATH_ENGINE_ASSERT_SVH
`define DIJKSTRA_SHORTEST_PATH_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DSPE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dspe assertion failed");

// Next-cycle implication, checked out of reset.
`define DSPE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dspe assertion failed");

`endif

[rtl/dspe_pkg.sv]
// Types, constants and state encodings of the shortest-path engine.
package dspe_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = 10;
    localparam int EDGE_SLOTS = 4096;
    localparam int SLOT_W     = 12;
    localparam int LINK_W     = 13;
    localparam int MAX_HOPS   = 64;
    localparam int HOP_W      = 7;
    localparam int COST_W     = 32;
    localparam int DIST_W     = 40;
    localparam int EKIND_W    = 4;
    localparam int NKIND_W    = 3;
    localparam int KEY_W      = DIST_W + NODE_W;
    localparam int HEAP_DEPTH = 4096;
    localparam int HEAP_AW    = 12;
    localparam int EDGE_W     = NODE_W + EKIND_W + COST_W;
    localparam int PAR_W      = NODE_W + SLOT_W;
    localparam int PATH_W     = NODE_W + PAR_W;

    localparam logic [COST_W-1:0] COST_UNUSABLE = '1;
    localparam logic [DIST_W-1:0] DIST_MAX      = '1;
    localparam logic [NODE_W-1:0] NODE_LAST     = NODE_W'(NODE_COUNT - 1);
    localparam logic [LINK_W-1:0] ECNT_MAX_OK   = LINK_W'(EDGE_SLOTS - 2);

    // Per-node search marks: bit 1 settled, bit 0 reached.
    localparam logic [1:0] MARK_NONE    = 2'b00;
    localparam logic [1:0] MARK_REACHED = 2'b01;
    localparam logic [1:0] MARK_SETTLED = 2'b11;

    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_KIND  = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NOPATH = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_TRUNC  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_SWEEP, S_IDLE, S_ADD_RD, S_ADD_WR,
        S_Q_CLR, S_Q_SEED, S_Q_POP, S_Q_POPW, S_Q_SETL, S_Q_HEAD,
        S_Q_EDGE, S_Q_ERD, S_Q_RELAX, S_Q_PUSH,
        S_TRACE, S_T_RD, S_T_WR, S_E_SETUP, S_E_RD, S_E_R2, S_E_R3, S_RES
    } top_state_t;

    typedef enum logic [2:0] {
        H_IDLE, H_UP, H_UPC, H_POPD, H_DN, H_DNC
    } heap_state_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        key_t key;
    } heap_cmd_t;

    typedef struct packed {
        logic busy;
        logic empty;
        key_t top;
    } heap_stat_t;

endpackage

[rtl/dijkstra_shortest_path_engine.sv]
// Shortest-path engine over an undirected typed graph: control, stores and result port.
//
// Input channel s_*: one item per action (s_tuser): clear graph, add undirected edge,
// set node type, query path. Result channel m_*: one item per add (status ok or store
// full), one per hop of a found path in order from the start node (m_tlast on the final
// hop; over 64 hops only the first 64, status trunc), or a single no-path
// item. Clear and set-type produce no result. Set-type is written as it is taken; add
// writes both entries of the edge; clear sweeps the node stores. A query first clears the
// per-node search marks, then walks the adjacency entries with heap pushes and pops that
// sift level by level, traces the parent links, and then issues the hop results. The
// single-port read of the search memories and the heap sift set its pace.
// One item is worked at a time; s_tready is high only between items.
// Reset: aresetn low (synchronous) drops all work; afterwards a sweep of all 1024 nodes
// empties the adjacency chains and node types before the first item is taken.
// A result waits in the output register while m_tready is low; the engine holds there and
// advances once the item is taken.
`include "dijkstra_shortest_path_engine_assert.svh"

module dijkstra_shortest_path_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] start_node, [19:10] end_node, [23:20] edge_kind, [55:24] edge_cost,
    // [58:56] node_kind, [63:59] zero
    input  logic [63:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [9:0] hop_from, [19:10] hop_to, [22:20] from_kind, [26:23] hop_edge_kind,
    // [66:27] path_cost, [71:67] zero
    output logic [71:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import dspe_pkg::*;

    // input fields
    action_t              in_action;
    logic [NODE_W-1:0]    in_start, in_end;
    logic [EKIND_W-1:0]   in_ekind;
    logic [COST_W-1:0]    in_cost;
    logic [NKIND_W-1:0]   in_nkind;
    logic                 s_accept;

    assign in_action = action_t'(s_tuser);
    assign in_start  = s_tdata[9:0];
    assign in_end    = s_tdata[19:10];
    assign in_ekind  = s_tdata[23:20];
    assign in_cost   = s_tdata[55:24];
    assign in_nkind  = s_tdata[58:56];

    // control and datapath registers
    top_state_t           state_reg, state_next;
    logic [NODE_W-1:0]    sweep_reg, sweep_next;
    logic [LINK_W-1:0]    ecnt_reg, ecnt_next;
    logic                 side_reg, side_next;
    logic [NODE_W-1:0]    src_reg, src_next, dst_reg, dst_next;
    logic [EKIND_W-1:0]   ekind_reg, ekind_next;
    logic [COST_W-1:0]    cost_reg, cost_next;
    logic [NODE_W-1:0]    u_reg, u_next, v_reg, v_next;
    logic [DIST_W-1:0]    d_reg, d_next, sum_reg, sum_next, dcost_reg, dcost_next;
    logic [LINK_W-1:0]    link_reg, link_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [COST_W-1:0]    c_reg, c_next;
    logic                 found_reg, found_next;
    logic [NODE_W-1:0]    x_reg, x_next, n_reg, n_next;
    logic [HOP_W-1:0]     hop_cnt_reg, hop_cnt_next, k_reg, k_next;
    logic                 trunc_reg, trunc_next;
    logic [NODE_W-1:0]    e_to_reg, e_to_next, e_from_reg, e_from_next;

    // pending result
    status_t              res_status_reg, res_status_next;
    logic [NODE_W-1:0]    res_from_reg, res_from_next, res_to_reg, res_to_next;
    logic [NKIND_W-1:0]   res_fkind_reg, res_fkind_next;
    logic [EKIND_W-1:0]   res_ekind_reg, res_ekind_next;
    logic [DIST_W-1:0]    res_cost_reg, res_cost_next;
    logic                 res_last_reg, res_last_next;
    logic                 res_hop_reg, res_hop_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [NODE_W-1:0]    out_from_reg, out_from_next, out_to_reg, out_to_next;
    logic [NKIND_W-1:0]   out_fkind_reg, out_fkind_next;
    logic [EKIND_W-1:0]   out_ekind_reg, out_ekind_next;
    logic [DIST_W-1:0]    out_cost_reg, out_cost_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // memories
    logic [LINK_W-1:0]  head_mem [NODE_COUNT];
    logic [LINK_W-1:0]  tail_mem [NODE_COUNT];
    logic [NKIND_W-1:0] nk_mem   [NODE_COUNT];
    logic [EDGE_W-1:0]  edge_mem [EDGE_SLOTS];
    logic [LINK_W-1:0]  nx_mem   [EDGE_SLOTS];
    logic [1:0]         st_mem   [NODE_COUNT];
    logic [DIST_W-1:0]  ds_mem   [NODE_COUNT];
    logic [PAR_W-1:0]   pr_mem   [NODE_COUNT];
    logic [PATH_W-1:0]  pt_mem   [NODE_COUNT];

    logic                head_we, tail_we, nk_we, edge_we, nx_we, st_we, ds_we, pr_we, pt_we;
    logic [NODE_W-1:0]   head_wa, head_ra, tail_wa, tail_ra, nk_wa, nk_ra;
    logic [NODE_W-1:0]   st_wa, st_ra, ds_wa, ds_ra, pr_wa, pr_ra, pt_wa, pt_ra;
    logic [SLOT_W-1:0]   edge_wa, edge_ra, nx_wa, nx_ra;
    logic [LINK_W-1:0]   head_wd, tail_wd, nx_wd;
    logic [NKIND_W-1:0]  nk_wd;
    logic [EDGE_W-1:0]   edge_wd;
    logic [1:0]          st_wd;
    logic [DIST_W-1:0]   ds_wd;
    logic [PAR_W-1:0]    pr_wd;
    logic [PATH_W-1:0]   pt_wd;
    logic [LINK_W-1:0]   head_q, tail_q, nx_q;
    logic [NKIND_W-1:0]  nk_q;
    logic [EDGE_W-1:0]   edge_q;
    logic [1:0]          st_q;
    logic [DIST_W-1:0]   ds_q;
    logic [PAR_W-1:0]    pr_q;
    logic [PATH_W-1:0]   pt_q;

    // heap
    heap_cmd_t  heap_cmd;
    heap_stat_t heap_st;

    dspe_heap u_heap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (heap_cmd),
        .stat    (heap_st)
    );

    // relaxation arithmetic: saturating 40-bit distance plus 32-bit cost
    logic [DIST_W:0]     sum_w;
    logic [DIST_W-1:0]   sat_w;
    logic                relax_w;
    logic [LINK_W-1:0]   slot_inc;
    logic [NODE_W-1:0]   add_u, add_v;
    logic [NODE_W-1:0]   par_from;

    assign sum_w    = {1'b0, d_reg} + {{(DIST_W + 1 - COST_W){1'b0}}, c_reg};
    assign sat_w    = sum_w[DIST_W] ? DIST_MAX : sum_w[DIST_W-1:0];
    assign relax_w  = !st_q[1] && (!st_q[0] || (sat_w < ds_q));
    assign slot_inc = ecnt_reg + 1'b1;
    assign add_u    = side_reg ? dst_reg : src_reg;
    assign add_v    = side_reg ? src_reg : dst_reg;
    assign par_from = pr_q[PAR_W-1:SLOT_W];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_SWEEP: begin
                if (sweep_reg == NODE_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    case (in_action)
                        ACT_CLEAR: state_next = S_SWEEP;
                        ACT_ADD:   state_next = (ecnt_reg > ECNT_MAX_OK) ? S_RES : S_ADD_RD;
                        ACT_KIND:  state_next = S_IDLE;
                        ACT_QUERY: state_next = (in_start == in_end) ? S_RES : S_Q_CLR;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD: state_next = S_ADD_WR;
            S_ADD_WR: state_next = side_reg ? S_RES : S_ADD_RD;
            S_Q_CLR: begin
                if (sweep_reg == NODE_LAST) begin
                    state_next = S_Q_SEED;
                end
            end
            S_Q_SEED: state_next = S_Q_POP;
            S_Q_POP: begin
                if (!heap_st.busy) begin
                    state_next = heap_st.empty ? S_TRACE : S_Q_POPW;
                end
            end
            S_Q_POPW: begin
                if (!heap_st.busy) begin
                    state_next = S_Q_SETL;
                end
            end
            S_Q_SETL: begin
                if (st_q[1]) begin
                    state_next = S_Q_POP;
                end else if (u_reg == dst_reg) begin
                    state_next = S_TRACE;
                end else begin
                    state_next = S_Q_HEAD;
                end
            end
            S_Q_HEAD: state_next = S_Q_EDGE;
            S_Q_EDGE: state_next = (link_reg == '0) ? S_Q_POP : S_Q_ERD;
            S_Q_ERD: begin
                state_next = (edge_q[COST_W-1:0] == COST_UNUSABLE) ? S_Q_EDGE : S_Q_RELAX;
            end
            S_Q_RELAX: state_next = relax_w ? S_Q_PUSH : S_Q_EDGE;
            S_Q_PUSH: begin
                if (!heap_st.busy) begin
                    state_next = S_Q_EDGE;
                end
            end
            S_TRACE:   state_next = found_reg ? S_T_RD : S_RES;
            S_T_RD:    state_next = S_T_WR;
            S_T_WR:    state_next = (par_from == src_reg) ? S_E_SETUP : S_T_RD;
            S_E_SETUP: state_next = S_E_RD;
            S_E_RD:    state_next = S_E_R2;
            S_E_R2:    state_next = S_E_R3;
            S_E_R3:    state_next = S_RES;
            S_RES: begin
                if (out_free) begin
                    state_next = (res_hop_reg && !res_last_reg) ? S_E_RD : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        sweep_next   = sweep_reg;
        ecnt_next    = ecnt_reg;
        side_next    = side_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        ekind_next   = ekind_reg;
        cost_next    = cost_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        d_next       = d_reg;
        sum_next     = sum_reg;
        dcost_next   = dcost_reg;
        link_next    = link_reg;
        slot_next    = slot_reg;
        c_next       = c_reg;
        found_next   = found_reg;
        x_next       = x_reg;
        n_next       = n_reg;
        hop_cnt_next = hop_cnt_reg;
        k_next       = k_reg;
        trunc_next   = trunc_reg;
        e_to_next    = e_to_reg;
        e_from_next  = e_from_reg;

        res_status_next = res_status_reg;
        res_from_next   = res_from_reg;
        res_to_next     = res_to_reg;
        res_fkind_next  = res_fkind_reg;
        res_ekind_next  = res_ekind_reg;
        res_cost_next   = res_cost_reg;
        res_last_next   = res_last_reg;
        res_hop_next    = res_hop_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_from_next   = out_from_reg;
        out_to_next     = out_to_reg;
        out_fkind_next  = out_fkind_reg;
        out_ekind_next  = out_ekind_reg;
        out_cost_next   = out_cost_reg;
        out_last_next   = out_last_reg;

        head_we = 1'b0; head_wa = sweep_reg; head_wd = '0; head_ra = u_reg;
        tail_we = 1'b0; tail_wa = sweep_reg; tail_wd = '0; tail_ra = add_u;
        nk_we   = 1'b0; nk_wa   = sweep_reg; nk_wd   = '0; nk_ra   = e_from_reg;
        edge_we = 1'b0; edge_wa = ecnt_reg[SLOT_W-1:0]; edge_wd = '0;
        edge_ra = slot_reg;
        nx_we   = 1'b0; nx_wa   = ecnt_reg[SLOT_W-1:0]; nx_wd   = '0;
        nx_ra   = slot_reg;
        st_we   = 1'b0; st_wa   = sweep_reg; st_wd   = MARK_NONE; st_ra = u_reg;
        ds_we   = 1'b0; ds_wa   = v_reg; ds_wd = sat_w; ds_ra = v_reg;
        pr_we   = 1'b0; pr_wa   = v_reg; pr_wd = {u_reg, slot_reg}; pr_ra = x_reg;
        pt_we   = 1'b0; pt_wa   = n_reg; pt_wd = '0;
        pt_ra   = n_reg - NODE_W'(1) - NODE_W'(k_reg);

        heap_cmd.clear = 1'b0;
        heap_cmd.push  = 1'b0;
        heap_cmd.pop   = 1'b0;
        heap_cmd.key   = {sum_reg, v_reg};

        case (state_reg)
            S_SWEEP: begin
                // empty the chains and node types, one node a cycle
                head_we    = 1'b1;
                tail_we    = 1'b1;
                nk_we      = 1'b1;
                sweep_next = sweep_reg + 1'b1;
            end
            S_IDLE: begin
                src_next   = in_start;
                dst_next   = in_end;
                ekind_next = in_ekind;
                cost_next  = in_cost;
                side_next  = 1'b0;
                found_next = 1'b0;
                sweep_next = '0;
                res_status_next = STAT_OK;
                res_from_next   = '0;
                res_to_next     = '0;
                res_fkind_next  = '0;
                res_ekind_next  = '0;
                res_cost_next   = '0;
                res_last_next   = 1'b1;
                res_hop_next    = 1'b0;
                if (s_accept) begin
                    case (in_action)
                        ACT_CLEAR: ecnt_next = '0;
                        ACT_ADD: begin
                            if (ecnt_reg > ECNT_MAX_OK) begin
                                res_status_next = STAT_FULL;
                            end
                        end
                        ACT_KIND: begin
                            nk_we = 1'b1;
                            nk_wa = in_start;
                            nk_wd = in_nkind;
                        end
                        ACT_QUERY: res_status_next = STAT_NOPATH;
                        default: ;
                    endcase
                end
            end
            S_ADD_RD: begin
                // store the new entry and fetch the chain tail of this endpoint
                edge_we = 1'b1;
                edge_wd = {add_v, ekind_reg, cost_reg};
                nx_we   = 1'b1;
            end
            S_ADD_WR: begin
                if (tail_q == '0) begin
                    head_we = 1'b1;
                    head_wa = add_u;
                    head_wd = slot_inc;
                end else begin
                    nx_we = 1'b1;
                    nx_wa = SLOT_W'(tail_q - 1'b1);
                    nx_wd = slot_inc;
                end
                tail_we   = 1'b1;
                tail_wa   = add_u;
                tail_wd   = slot_inc;
                ecnt_next = slot_inc;
                side_next = 1'b1;
            end
            S_Q_CLR: begin
                // drop the marks of the previous search and empty the heap
                st_we          = 1'b1;
                heap_cmd.clear = 1'b1;
                sweep_next     = sweep_reg + 1'b1;
            end
            S_Q_SEED: begin
                st_we         = 1'b1;
                st_wa         = src_reg;
                st_wd         = MARK_REACHED;
                ds_we         = 1'b1;
                ds_wa         = src_reg;
                ds_wd         = '0;
                heap_cmd.push = 1'b1;
                heap_cmd.key  = {{DIST_W{1'b0}}, src_reg};
            end
            S_Q_POP: begin
                if (!heap_st.busy && !heap_st.empty) begin
                    heap_cmd.pop = 1'b1;
                end
            end
            S_Q_POPW: begin
                u_next = heap_st.top[NODE_W-1:0];
                d_next = heap_st.top[KEY_W-1:NODE_W];
                st_ra  = heap_st.top[NODE_W-1:0];
            end
            S_Q_SETL: begin
                if (!st_q[1]) begin
                    st_we = 1'b1;
                    st_wa = u_reg;
                    st_wd = MARK_SETTLED;
                    if (u_reg == dst_reg) begin
                        found_next = 1'b1;
                        dcost_next = d_reg;
                    end
                end
            end
            S_Q_HEAD: link_next = head_q;
            S_Q_EDGE: begin
                edge_ra   = SLOT_W'(link_reg - 1'b1);
                nx_ra     = SLOT_W'(link_reg - 1'b1);
                slot_next = SLOT_W'(link_reg - 1'b1);
            end
            S_Q_ERD: begin
                link_next = nx_q;
                v_next    = edge_q[EDGE_W-1:EKIND_W+COST_W];
                c_next    = edge_q[COST_W-1:0];
                st_ra     = edge_q[EDGE_W-1:EKIND_W+COST_W];
                ds_ra     = edge_q[EDGE_W-1:EKIND_W+COST_W];
            end
            S_Q_RELAX: begin
                if (relax_w) begin
                    st_we    = 1'b1;
                    st_wa    = v_reg;
                    st_wd    = MARK_REACHED;
                    ds_we    = 1'b1;
                    pr_we    = 1'b1;
                    sum_next = sat_w;
                end
            end
            S_Q_PUSH: begin
                if (!heap_st.busy) begin
                    heap_cmd.push = 1'b1;
                end
            end
            S_TRACE: begin
                x_next = dst_reg;
                n_next = '0;
            end
            S_T_WR: begin
                // record this hop, newest at the highest index
                pt_we  = 1'b1;
                pt_wd  = {x_reg, pr_q};
                n_next = n_reg + 1'b1;
                x_next = par_from;
            end
            S_E_SETUP: begin
                k_next = '0;
                if (n_reg > NODE_W'(MAX_HOPS)) begin
                    hop_cnt_next = HOP_W'(MAX_HOPS);
                    trunc_next   = 1'b1;
                end else begin
                    hop_cnt_next = n_reg[HOP_W-1:0];
                    trunc_next   = 1'b0;
                end
            end
            S_E_R2: begin
                e_to_next   = pt_q[PATH_W-1:PAR_W];
                e_from_next = pt_q[PAR_W-1:SLOT_W];
                nk_ra       = pt_q[PAR_W-1:SLOT_W];
                edge_ra     = pt_q[SLOT_W-1:0];
            end
            S_E_R3: begin
                res_status_next = trunc_reg ? STAT_TRUNC : STAT_OK;
                res_from_next   = e_from_reg;
                res_to_next     = e_to_reg;
                res_fkind_next  = nk_q;
                res_ekind_next  = edge_q[EKIND_W+COST_W-1:COST_W];
                res_cost_next   = dcost_reg;
                res_last_next   = ((k_reg + 1'b1) == hop_cnt_reg);
                res_hop_next    = 1'b1;
                k_next          = k_reg + 1'b1;
            end
            S_RES: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_from_next   = res_from_reg;
                    out_to_next     = res_to_reg;
                    out_fkind_next  = res_fkind_reg;
                    out_ekind_next  = res_ekind_reg;
                    out_cost_next   = res_cost_reg;
                    out_last_next   = res_last_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            sweep_reg     <= '0;
            ecnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            hop_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            ecnt_reg      <= ecnt_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            hop_cnt_reg   <= hop_cnt_next;
        end
        side_reg       <= side_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        ekind_reg      <= ekind_next;
        cost_reg       <= cost_next;
        u_reg          <= u_next;
        v_reg          <= v_next;
        d_reg          <= d_next;
        sum_reg        <= sum_next;
        dcost_reg      <= dcost_next;
        link_reg       <= link_next;
        slot_reg       <= slot_next;
        c_reg          <= c_next;
        x_reg          <= x_next;
        n_reg          <= n_next;
        k_reg          <= k_next;
        trunc_reg      <= trunc_next;
        e_to_reg       <= e_to_next;
        e_from_reg     <= e_from_next;
        res_status_reg <= res_status_next;
        res_from_reg   <= res_from_next;
        res_to_reg     <= res_to_next;
        res_fkind_reg  <= res_fkind_next;
        res_ekind_reg  <= res_ekind_next;
        res_cost_reg   <= res_cost_next;
        res_last_reg   <= res_last_next;
        res_hop_reg    <= res_hop_next;
        out_status_reg <= out_status_next;
        out_from_reg   <= out_from_next;
        out_to_reg     <= out_to_next;
        out_fkind_reg  <= out_fkind_next;
        out_ekind_reg  <= out_ekind_next;
        out_cost_reg   <= out_cost_next;
        out_last_reg   <= out_last_next;
    end

    // graph stores
    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_wa] <= head_wd;
        end
        head_q <= head_mem[head_ra];
    end

    always_ff @(posedge aclk) begin
        if (tail_we) begin
            tail_mem[tail_wa] <= tail_wd;
        end
        tail_q <= tail_mem[tail_ra];
    end

    always_ff @(posedge aclk) begin
        if (nk_we) begin
            nk_mem[nk_wa] <= nk_wd;
        end
        nk_q <= nk_mem[nk_ra];
    end

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            edge_mem[edge_wa] <= edge_wd;
        end
        edge_q <= edge_mem[edge_ra];
    end

    always_ff @(posedge aclk) begin
        if (nx_we) begin
            nx_mem[nx_wa] <= nx_wd;
        end
        nx_q <= nx_mem[nx_ra];
    end

    // search stores
    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[st_wa] <= st_wd;
        end
        st_q <= st_mem[st_ra];
    end

    always_ff @(posedge aclk) begin
        if (ds_we) begin
            ds_mem[ds_wa] <= ds_wd;
        end
        ds_q <= ds_mem[ds_ra];
    end

    always_ff @(posedge aclk) begin
        if (pr_we) begin
            pr_mem[pr_wa] <= pr_wd;
        end
        pr_q <= pr_mem[pr_ra];
    end

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            pt_mem[pt_wa] <= pt_wd;
        end
        pt_q <= pt_mem[pt_ra];
    end

    // result port
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b0, out_cost_reg, out_ekind_reg, out_fkind_reg,
                       out_to_reg, out_from_reg};

    // a push only goes to an idle heap
    `DSPE_ASSERT_IMP(a_push_idle, aclk, aresetn, heap_cmd.push, !heap_st.busy)
    // a truncated path always reports the full hop budget
    `DSPE_ASSERT_IMP(a_trunc_count, aclk, aresetn,
                     m_tvalid && (m_tuser == STAT_TRUNC), hop_cnt_reg == HOP_W'(MAX_HOPS))
    // only hop results run over more than one item
    `DSPE_ASSERT_IMP(a_multi_hop, aclk, aresetn, m_tvalid && !m_tlast,
                     (m_tuser == STAT_OK) || (m_tuser == STAT_TRUNC))

endmodule

[rtl/dspe_heap.sv]
// Binary min-heap of search candidates kept in one dual-read memory.
module dspe_heap (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dspe_pkg::heap_cmd_t   cmd,
    output dspe_pkg::heap_stat_t  stat
);
    import dspe_pkg::*;

    heap_state_t          state_reg, state_next;
    logic [HEAP_AW:0]     cnt_reg, cnt_next;
    logic [HEAP_AW-1:0]   idx_reg, idx_next;
    key_t                 key_reg, key_next;
    key_t                 top_reg, top_next;

    key_t                 mem [HEAP_DEPTH];
    logic [HEAP_AW-1:0]   rda_addr, rdb_addr, wr_addr;
    key_t                 rda_q, rdb_q, wr_data;
    logic                 wr_en;

    logic [HEAP_AW:0]     cnt_m1;
    logic [HEAP_AW-1:0]   parent_w;
    logic [HEAP_AW+1:0]   left_w, right_w;
    logic                 pick_right;
    key_t                 child_key;
    logic [HEAP_AW-1:0]   child_idx;

    assign cnt_m1     = cnt_reg - 1'b1;
    assign parent_w   = (idx_reg - 1'b1) >> 1;
    assign left_w     = {1'b0, idx_reg, 1'b1};
    assign right_w    = left_w + 1'b1;
    assign pick_right = (right_w < {1'b0, cnt_reg}) && (rdb_q < rda_q);
    assign child_key  = pick_right ? rdb_q : rda_q;
    assign child_idx  = pick_right ? right_w[HEAP_AW-1:0] : left_w[HEAP_AW-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            H_IDLE: begin
                if (cmd.push) begin
                    state_next = H_UP;
                end else if (cmd.pop) begin
                    state_next = H_POPD;
                end
            end
            H_UP:   state_next = (idx_reg == '0) ? H_IDLE : H_UPC;
            H_UPC:  state_next = (key_reg < rda_q) ? H_UP : H_IDLE;
            H_POPD: state_next = (cnt_m1 == '0) ? H_IDLE : H_DN;
            H_DN:   state_next = (left_w >= {1'b0, cnt_reg}) ? H_IDLE : H_DNC;
            H_DNC:  state_next = (child_key < key_reg) ? H_DN : H_IDLE;
            default: state_next = H_IDLE;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        key_next = key_reg;
        top_next = top_reg;
        rda_addr = '0;
        rdb_addr = '0;
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_data  = key_reg;
        case (state_reg)
            H_IDLE: begin
                if (cmd.clear) begin
                    cnt_next = '0;
                end
                if (cmd.push) begin
                    idx_next = cnt_reg[HEAP_AW-1:0];
                    key_next = cmd.key;
                    cnt_next = cnt_reg + 1'b1;
                end else if (cmd.pop) begin
                    rdb_addr = cnt_m1[HEAP_AW-1:0];
                end
            end
            H_UP: begin
                if (idx_reg == '0) begin
                    wr_en = 1'b1;
                end else begin
                    rda_addr = parent_w;
                end
            end
            H_UPC: begin
                wr_en = 1'b1;
                if (key_reg < rda_q) begin
                    wr_data  = rda_q;
                    idx_next = parent_w;
                end
            end
            H_POPD: begin
                top_next = rda_q;
                key_next = rdb_q;
                cnt_next = cnt_m1;
                idx_next = '0;
            end
            H_DN: begin
                if (left_w >= {1'b0, cnt_reg}) begin
                    wr_en = 1'b1;
                end else begin
                    rda_addr = left_w[HEAP_AW-1:0];
                    rdb_addr = right_w[HEAP_AW-1:0];
                end
            end
            H_DNC: begin
                wr_en = 1'b1;
                if (child_key < key_reg) begin
                    wr_data  = child_key;
                    idx_next = child_idx;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        idx_reg <= idx_next;
        key_reg <= key_next;
        top_reg <= top_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rda_q <= mem[rda_addr];
        rdb_q <= mem[rdb_addr];
    end

    assign stat.busy  = (state_reg != H_IDLE);
    assign stat.empty = (cnt_reg == '0);
    assign stat.top   = top_reg;

endmodule

[test/tb_dijkstra_shortest_path_engine.sv]
// Testbench of the shortest-path engine: random and directed graph actions, checked per hop.
module tb_dijkstra_shortest_path_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import dspe_pkg::*;

    // One expected hop item on the result channel.
    typedef struct {
        status_t          status;
        logic [NODE_W-1:0]  hop_from;
        logic [NODE_W-1:0]  hop_to;
        logic [NKIND_W-1:0] from_kind;
        logic [EKIND_W-1:0] edge_kind;
        logic [DIST_W-1:0]  cost;
        logic               last;
    } hop_t;

    // Keeps its own copy of the graph, predicts every hop and checks the result channel.
    class path_scoreboard;
        logic [NKIND_W-1:0] kind_of [NODE_COUNT];
        int                 chain_head [NODE_COUNT];   // slot + 1, 0 = empty
        int                 chain_tail [NODE_COUNT];
        logic [NODE_W-1:0]  slot_to [EDGE_SLOTS];
        logic [EKIND_W-1:0] slot_kind [EDGE_SLOTS];
        logic [COST_W-1:0]  slot_cost [EDGE_SLOTS];
        int                 slot_next [EDGE_SLOTS];
        int                 slots_used;
        logic [DIST_W-1:0]  dist_of [NODE_COUNT];
        bit                 reached [NODE_COUNT];
        bit                 settled [NODE_COUNT];
        int                 via_node [NODE_COUNT];
        int                 via_slot [NODE_COUNT];
        hop_t               hops_due [$];
        int                 failures;

        function new();
            foreach (kind_of[i]) begin
                kind_of[i] = '0;
                chain_head[i] = 0;
                chain_tail[i] = 0;
            end
            slots_used = 0;
            failures = 0;
        endfunction

        function void push_hop(status_t st, int f, int t, int fk, int ek,
                               logic [DIST_W-1:0] c, bit l);
            hop_t h;
            h.status = st;
            h.hop_from = NODE_W'(f);
            h.hop_to = NODE_W'(t);
            h.from_kind = NKIND_W'(fk);
            h.edge_kind = EKIND_W'(ek);
            h.cost = c;
            h.last = l;
            hops_due = {hops_due, h};
        endfunction

        function void link_entry(int u, int v, int ek, logic [COST_W-1:0] c);
            int s;
            s = slots_used;
            slots_used++;
            slot_to[s] = NODE_W'(v);
            slot_kind[s] = EKIND_W'(ek);
            slot_cost[s] = c;
            slot_next[s] = 0;
            if (chain_head[u] == 0)
                chain_head[u] = s + 1;
            else
                slot_next[chain_tail[u]] = s + 1;
            chain_tail[u] = s;
        endfunction

        // Settle nodes by least distance, lowest index on ties; strict less-than relaxation.
        function void search(int src, int dst);
            int u;
            int link;
            int s;
            int v;
            logic [DIST_W:0] sum;
            foreach (settled[i]) begin
                settled[i] = 0;
                reached[i] = 0;
            end
            reached[src] = 1;
            dist_of[src] = '0;
            forever begin
                u = -1;
                for (int i = 0; i < NODE_COUNT; i++)
                    if (reached[i] && !settled[i] && (u < 0 || dist_of[i] < dist_of[u]))
                        u = i;
                if (u < 0)
                    break;
                settled[u] = 1;
                if (u == dst)
                    break;
                link = chain_head[u];
                while (link != 0) begin
                    s = link - 1;
                    v = slot_to[s];
                    link = slot_next[s];
                    if (slot_cost[s] == COST_UNUSABLE || settled[v])
                        continue;
                    sum = {1'b0, dist_of[u]} + slot_cost[s];
                    if (sum[DIST_W])
                        sum = {1'b0, DIST_MAX};
                    if (!reached[v] || sum[DIST_W-1:0] < dist_of[v]) begin
                        reached[v] = 1;
                        dist_of[v] = sum[DIST_W-1:0];
                        via_node[v] = u;
                        via_slot[v] = s;
                    end
                end
            end
        endfunction

        function void note_item(action_t act, int a, int b, int ek,
                                logic [COST_W-1:0] c, int nk);
            int trail [$];
            int x;
            int count;
            int t;
            status_t st;
            case (act)
                ACT_CLEAR: begin
                    foreach (kind_of[i]) begin
                        kind_of[i] = '0;
                        chain_head[i] = 0;
                    end
                    slots_used = 0;
                end
                ACT_KIND: begin
                    kind_of[a] = NKIND_W'(nk);
                end
                ACT_ADD: begin
                    if (slots_used + 2 > EDGE_SLOTS) begin
                        push_hop(STAT_FULL, 0, 0, 0, 0, '0, 1);
                    end else begin
                        link_entry(a, b, ek, c);
                        link_entry(b, a, ek, c);
                        push_hop(STAT_OK, 0, 0, 0, 0, '0, 1);
                    end
                end
                default: begin
                    if (a == b) begin
                        push_hop(STAT_NOPATH, 0, 0, 0, 0, '0, 1);
                        return;
                    end
                    search(a, b);
                    if (!reached[b]) begin
                        push_hop(STAT_NOPATH, 0, 0, 0, 0, '0, 1);
                        return;
                    end
                    x = b;
                    while (x != a && trail.size() < NODE_COUNT) begin
                        trail = {trail, x};
                        x = via_node[x];
                    end
                    count = trail.size() > MAX_HOPS ? MAX_HOPS : trail.size();
                    st = trail.size() > MAX_HOPS ? STAT_TRUNC : STAT_OK;
                    for (int k = 0; k < count; k++) begin
                        t = trail[trail.size() - 1 - k];
                        push_hop(st, via_node[t], t, kind_of[via_node[t]],
                                 slot_kind[via_slot[t]], dist_of[b], k + 1 == count);
                    end
                end
            endcase
        endfunction

        function void check_result(hop_t got);
            hop_t want;
            if (hops_due.size() == 0) begin
                $error("result item with nothing expected: status %0d", got.status);
                failures++;
                return;
            end
            want = hops_due.pop_front();
            if (got.status != want.status) begin
                $error("status expected %0d got %0d", want.status, got.status);
                failures++;
            end
            if (got.hop_from != want.hop_from) begin
                $error("hop_from expected %0d got %0d", want.hop_from, got.hop_from);
                failures++;
            end
            if (got.hop_to != want.hop_to) begin
                $error("hop_to expected %0d got %0d", want.hop_to, got.hop_to);
                failures++;
            end
            if (got.from_kind != want.from_kind) begin
                $error("from_kind expected %0d got %0d", want.from_kind, got.from_kind);
                failures++;
            end
            if (got.edge_kind != want.edge_kind) begin
                $error("hop_edge_kind expected %0d got %0d", want.edge_kind, got.edge_kind);
                failures++;
            end
            if (got.cost != want.cost) begin
                $error("path_cost expected %0h got %0h", want.cost, got.cost);
                failures++;
            end
            if (got.last != want.last) begin
                $error("last expected %0d got %0d", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    path_scoreboard board;
    bit             calm;          // no new idling started on either side while set
    int             idle_cycles;   // cycles since the last accepted item on either side
    int             random_items;
    int             ready_stall;

    localparam int WATCHDOG_LIMIT = 600000;

    dijkstra_shortest_path_engine i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Present one item and hold it until the engine takes it.
    task automatic send_item(action_t act, int a, int b, int ek,
                             logic [COST_W-1:0] c, int nk);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {5'b0, NKIND_W'(nk), c, EKIND_W'(ek), NODE_W'(b), NODE_W'(a)};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drop_valid();
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (board.hops_due.size() != 0)
            @(negedge aclk);
    endtask

    function automatic logic [COST_W-1:0] pick_cost();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return COST_UNUSABLE;
        if (r == 2) return COST_UNUSABLE - 1;
        if (r < 6)  return $urandom;
        return $urandom_range(1, 2000) << 16;
    endfunction

    // Optional clear, small random graph on nodes near a random base, node types, then queries between them.
    task automatic small_graph_round();
        int base;
        int span;
        int n;
        base = $urandom_range(0, NODE_COUNT - 1);
        span = $urandom_range(3, 12);
        calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) != 0) begin
            send_item(ACT_CLEAR, $urandom, $urandom, 0, '0, 0);
            random_items++;
        end
        n = $urandom_range(3, 14);
        repeat (n) begin
            send_item(ACT_ADD, (base + $urandom_range(0, span)) % NODE_COUNT,
                      (base + $urandom_range(0, span)) % NODE_COUNT,
                      $urandom_range(0, 10), pick_cost(), $urandom_range(0, 7));
            random_items++;
        end
        repeat ($urandom_range(0, 3)) begin
            send_item(ACT_KIND, (base + $urandom_range(0, span)) % NODE_COUNT,
                      $urandom, $urandom_range(0, 15), $urandom, $urandom_range(0, 4));
            random_items++;
        end
        repeat ($urandom_range(1, 4)) begin
            send_item(ACT_QUERY, (base + $urandom_range(0, span)) % NODE_COUNT,
                      (base + $urandom_range(0, span)) % NODE_COUNT,
                      $urandom_range(0, 15), $urandom, $urandom_range(0, 7));
            random_items++;
        end
        // Occasional stray add, set-type or query item with random fields.
        if ($urandom_range(0, 3) == 0) begin
            send_item(action_t'($urandom_range(1, 3)), $urandom_range(0, NODE_COUNT - 1),
                      $urandom_range(0, NODE_COUNT - 1), $urandom_range(0, 10),
                      $urandom, $urandom_range(0, 4));
            random_items++;
        end
    endtask

    // Input monitor: feed the predictor on every accepted item.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            board.note_item(action_t'(s_tuser), s_tdata[9:0], s_tdata[19:10],
                            s_tdata[23:20], s_tdata[55:24], s_tdata[58:56]);
    end

    // Result monitor: check each accepted hop against the oldest expectation.
    always @(posedge aclk) begin
        hop_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status    = status_t'(m_tuser);
            got.hop_from  = m_tdata[9:0];
            got.hop_to    = m_tdata[19:10];
            got.from_kind = m_tdata[22:20];
            got.edge_kind = m_tdata[26:23];
            got.cost      = m_tdata[66:27];
            got.last      = m_tlast;
            board.check_result(got);
        end
    end

    // Receiver: stall at random, never starting a stall while calm.
    always @(negedge aclk) begin
        if (ready_stall > 0) begin
            m_tready <= 1'b0;
            ready_stall <= ready_stall - 1;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
                ready_stall <= gap_len();
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        board        = new();
        calm         = 1'b0;
        idle_cycles  = 0;
        ready_stall  = 0;
        random_items = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ACT_CLEAR;
        m_tready     = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty graph, ties, self loop, unusable edge, extremes of node and cost.
        send_item(ACT_QUERY, 0, 1, 0, '0, 0);
        send_item(ACT_ADD, 0, 1, 10, 32'd5, 0);
        send_item(ACT_ADD, 1, 2, 3, 32'd7, 0);
        send_item(ACT_ADD, 0, 2, 8, 32'd12, 0);       // equal-cost route, found second
        send_item(ACT_ADD, 2, 2, 5, 32'd1, 0);        // self loop
        send_item(ACT_ADD, 0, 3, 1, COST_UNUSABLE, 0);
        send_item(ACT_KIND, 0, 0, 0, '0, 4);
        send_item(ACT_KIND, 1, 0, 0, '0, 3);
        send_item(ACT_QUERY, 0, 2, 0, '0, 0);
        send_item(ACT_QUERY, 2, 0, 0, '0, 0);
        send_item(ACT_QUERY, 0, 3, 0, '0, 0);         // only an unusable edge leads there
        send_item(ACT_QUERY, 2, 2, 0, '0, 0);         // start equals end
        send_item(ACT_ADD, 1023, 1022, 0, '0, 7);
        send_item(ACT_ADD, 1022, 512, 15, COST_UNUSABLE - 1, 0);
        send_item(ACT_KIND, 1023, 1023, 15, COST_UNUSABLE, 1);
        send_item(ACT_QUERY, 1023, 512, 15, COST_UNUSABLE, 7);
        send_item(ACT_QUERY, 512, 1023, 0, '0, 0);
        send_item(ACT_QUERY, 0, 1023, 0, '0, 0);
        send_item(ACT_CLEAR, 1023, 1023, 15, COST_UNUSABLE, 7);
        send_item(ACT_QUERY, 0, 2, 0, '0, 0);
        send_item(ACT_QUERY, 1023, 1022, 0, '0, 0);

        // Hold off until every expected hop has come back.
        wait_drained();

        // Long chain of near-maximum costs: truncation at the hop limit.
        send_item(ACT_CLEAR, 0, 0, 0, '0, 0);
        for (int i = 0; i < 66; i++)
            send_item(ACT_ADD, 100 + i, 101 + i, i % 11, COST_UNUSABLE - 1, 0);
        send_item(ACT_KIND, 100, 0, 0, '0, 2);
        send_item(ACT_QUERY, 100, 166, 0, '0, 0);
        send_item(ACT_QUERY, 166, 100, 0, '0, 0);
        send_item(ACT_QUERY, 100, 164, 0, '0, 0);     // exactly the hop limit
        send_item(ACT_QUERY, 100, 165, 0, '0, 0);     // one hop over it

        // Random rounds of small graphs until the item budget is spent.
        while (random_items < 10)
            small_graph_round();
        calm = 1'b0;

        wait_drained();
        repeat (2000) @(posedge aclk);
        if (board.failures == 0 && board.hops_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
